// File: hw/rtl/a2u_pkg.sv
// ----------------------------------------------------------------------------
// a2u_pkg
// shared types and constants of the ascii to u64 parser
// ----------------------------------------------------------------------------
package a2u_pkg;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = $clog2(QDEPTH);

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_DEC   = 3'd1;
	localparam logic [2:0] ST_OVF_DEC   = 3'd2;
	localparam logic [2:0] ST_BAD_HEX   = 3'd3;
	localparam logic [2:0] ST_OVF_HEX   = 3'd4;
	localparam logic [2:0] ST_EMPTY_HEX = 3'd5;

	localparam logic [63:0] DEC_TOP = 64'd1844674407370955161;

	// classified character
	typedef struct packed {
		logic [7:0] ch;
		logic [3:0] digit;
		logic       is_dec;
		logic       is_hex;
		logic       is_zero;
		logic       is_x;
		logic       last;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

endpackage

// File: hw/rtl/a2u_front.sv
// ----------------------------------------------------------------------------
// a2u_front
// accepts characters, classifies them and pushes them into the queue
// ----------------------------------------------------------------------------
module a2u_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            char_valid,
	output logic            char_stall,
	input  logic [7:0]      char_code,
	input  logic            is_last,
	input  a2u_pkg::qstat_t q_stat,
	output logic            q_push,
	output a2u_pkg::item_t  q_item
);
	import a2u_pkg::*;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_LA   = 8'h61;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UF   = 8'h46;
	localparam logic [7:0] CH_LX   = 8'h78;
	localparam logic [7:0] CH_UX   = 8'h58;

	item_t cls;
	item_t item_s1;
	logic  valid_s1;
	logic  adv;
	logic  is_alpha;

	always_comb begin
		cls.ch      = char_code;
		cls.is_dec  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		is_alpha    = ((char_code >= CH_LA) && (char_code <= CH_LF)) ||
		              ((char_code >= CH_UA) && (char_code <= CH_UF));
		cls.is_hex  = cls.is_dec || is_alpha;
		cls.is_zero = (char_code == CH_ZERO);
		cls.is_x    = (char_code == CH_LX) || (char_code == CH_UX);
		cls.last    = is_last;
		priority if (cls.is_dec) begin
			cls.digit = char_code[3:0];
		end else if (is_alpha) begin
			cls.digit = char_code[3:0] + 4'd9;
		end else begin
			cls.digit = 4'd0;
		end
	end

	assign adv        = !valid_s1 || !q_stat.full;
	assign char_stall = !adv;
	assign q_push     = valid_s1 && !q_stat.full;
	assign q_item     = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && char_valid) begin
			item_s1 <= cls;
		end
	end

endmodule

// File: hw/rtl/a2u_queue.sv
// ----------------------------------------------------------------------------
// a2u_queue
// short queue of classified items between front and back
// ----------------------------------------------------------------------------
module a2u_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  a2u_pkg::item_t  wr_item,
	input  logic            pop,
	output a2u_pkg::item_t  rd_item,
	output a2u_pkg::qstat_t stat
);
	import a2u_pkg::*;

	item_t          mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign stat.full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_item    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

// File: hw/rtl/a2u_back.sv
// ----------------------------------------------------------------------------
// a2u_back
// accumulates digits, latches the first error and registers the result
// ----------------------------------------------------------------------------
module a2u_back (
	input  logic            clk,
	input  logic            arst_n,
	input  a2u_pkg::qstat_t q_stat,
	input  a2u_pkg::item_t  q_item,
	output logic            q_pop,
	output logic            res_valid,
	input  logic            res_stall,
	output logic [63:0]     value,
	output logic [2:0]      status,
	output logic [7:0]      bad_char
);
	import a2u_pkg::*;

	typedef enum logic [1:0] {
		POS_FIRST,
		POS_SECOND,
		POS_REST,
		POS_HEXDIG
	} pos_t;

	logic [63:0] acc_q, acc_n;
	pos_t        pos_q, pos_n;
	logic        hex_q, hex_n;
	logic        fz_q, fz_n;
	logic [2:0]  err_q, err_n;
	logic [7:0]  ech_q, ech_n;
	logic        res_valid_q;
	logic [63:0] value_q;
	logic [2:0]  status_q;
	logic [7:0]  bad_char_q;

	logic [63:0] dec_prod;
	logic [64:0] dec_sum;
	logic        ok;
	logic        do_dec;
	logic        do_hex;
	logic [2:0]  fin_status;

	assign q_pop = !q_stat.empty && (!res_valid_q || !res_stall);

	always_comb begin
		acc_n    = acc_q;
		pos_n    = pos_q;
		hex_n    = hex_q;
		fz_n     = fz_q;
		err_n    = err_q;
		ech_n    = ech_q;
		ok       = (err_q == ST_OK);
		do_dec   = 1'b0;
		do_hex   = 1'b0;
		dec_prod = (acc_q << 3) + (acc_q << 1);
		dec_sum  = {1'b0, dec_prod} + {61'd0, q_item.digit};

		unique case (pos_q)
			POS_FIRST: begin
				fz_n   = q_item.is_zero;
				do_dec = ok;
				pos_n  = POS_SECOND;
			end
			POS_SECOND: begin
				if (fz_q && q_item.is_x && ok) begin
					hex_n = 1'b1;
					acc_n = '0;
				end else begin
					do_dec = ok;
				end
				pos_n = POS_REST;
			end
			POS_REST, POS_HEXDIG: begin
				if (hex_q) begin
					do_hex = ok;
					pos_n  = POS_HEXDIG;
				end else begin
					do_dec = ok;
				end
			end
		endcase

		if (do_dec) begin
			priority if (acc_q > DEC_TOP) begin
				err_n = ST_OVF_DEC;
				ech_n = 8'd0;
			end else if (!q_item.is_dec) begin
				err_n = ST_BAD_DEC;
				ech_n = q_item.ch;
			end else if (dec_sum[64]) begin
				err_n = ST_OVF_DEC;
				ech_n = 8'd0;
			end else begin
				acc_n = dec_sum[63:0];
			end
		end

		if (do_hex) begin
			priority if (acc_q[63:60] != 4'd0) begin
				err_n = ST_OVF_HEX;
				ech_n = 8'd0;
			end else if (!q_item.is_hex) begin
				err_n = ST_BAD_HEX;
				ech_n = q_item.ch;
			end else begin
				acc_n = {acc_q[59:0], q_item.digit};
			end
		end

		if ((err_n == ST_OK) && hex_n && (pos_n != POS_HEXDIG)) begin
			fin_status = ST_EMPTY_HEX;
		end else begin
			fin_status = err_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pos_q       <= POS_FIRST;
			hex_q       <= 1'b0;
			fz_q        <= 1'b0;
			err_q       <= ST_OK;
			ech_q       <= 8'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_item.last) begin
					acc_q <= '0;
					pos_q <= POS_FIRST;
					hex_q <= 1'b0;
					fz_q  <= 1'b0;
					err_q <= ST_OK;
					ech_q <= 8'd0;
				end else begin
					acc_q <= acc_n;
					pos_q <= pos_n;
					hex_q <= hex_n;
					fz_q  <= fz_n;
					err_q <= err_n;
					ech_q <= ech_n;
				end
			end
			if (q_pop && q_item.last) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_item.last) begin
			value_q    <= (fin_status == ST_OK) ? acc_n : 64'd0;
			status_q   <= fin_status;
			bad_char_q <= ((fin_status == ST_BAD_DEC) || (fin_status == ST_BAD_HEX))
			              ? ech_n : 8'd0;
		end
	end

	assign res_valid = res_valid_q;
	assign value     = value_q;
	assign status    = status_q;
	assign bad_char  = bad_char_q;

endmodule

// File: hw/rtl/ascii_to_u64_parser_top.sv
// ----------------------------------------------------------------------------
// ascii_to_u64_parser_top
// parses a decimal or 0x-prefixed hex text into an unsigned 64-bit value
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------
//  char    | char_valid, char_stall | char_code[7:0], is_last
//  res     | res_valid, res_stall   | value[63:0], status[2:0], bad_char[7:0]
//
//  one character per cycle sustained while the queue is not full and res does not
//  stall, set by the multiply-by-ten and add of the accumulator in the back part
//  a result passes the front register and the queue before it is registered in the back part
//  arst_n clears all control state and the parse state; no clearing pass
//  a four-item queue lets the front keep taking characters while res stalls
// ----------------------------------------------------------------------------
module ascii_to_u64_parser_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	output logic        char_stall,
	input  logic [7:0]  char_code,
	input  logic        is_last,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [63:0] value,
	output logic [2:0]  status,
	output logic [7:0]  bad_char
);
	import a2u_pkg::*;

	qstat_t q_stat;
	logic   q_push;
	logic   q_pop;
	item_t  q_wr_item;
	item_t  q_rd_item;

	a2u_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.is_last    (is_last),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_item     (q_wr_item)
	);

	a2u_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_item (q_wr_item),
		.pop     (q_pop),
		.rd_item (q_rd_item),
		.stat    (q_stat)
	);

	a2u_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.q_item    (q_rd_item),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.value     (value),
		.status    (status),
		.bad_char  (bad_char)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("push into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (status != ST_OK)) |-> (value == 64'd0))
		else $error("nonzero value with error status");

	a_bad_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (bad_char != 8'd0)) |-> ((status == ST_BAD_DEC) || (status == ST_BAD_HEX)))
		else $error("bad_char set without bad digit status");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(q_stat.full && !q_pop && $past(q_push)) |-> ##0 (q_push == 1'b0))
		else $error("queue accepted item while full");

endmodule

// File: dv/ascii_to_u64_parser_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ascii_to_u64_parser_top_test
// sends decimal, 0x-prefixed hex, malformed and noise texts, one character per item, and checks
// every parsed value, status and bad character against a predictor kept in
// step with the accepted characters; idling on both channels varies by phase
// ----------------------------------------------------------------------------
module ascii_to_u64_parser_top_test;
	import a2u_pkg::*;

	localparam logic [63:0] HEX_LIMIT   = 64'h0FFF_FFFF_FFFF_FFFF;
	localparam int          CYCLE_LIMIT = 400000;
	localparam int          MAX_REPORTS = 10;

	typedef struct packed {
		logic [63:0] value;
		logic [2:0]  status;
		logic [7:0]  bad_char;
	} parse_result_t;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        char_valid = 1'b0;
	logic [7:0]  char_code  = 8'd0;
	logic        is_last    = 1'b0;
	logic        res_stall  = 1'b0;
	logic        char_stall;
	logic        res_valid;
	logic [63:0] value;
	logic [2:0]  status;
	logic [7:0]  bad_char;

	int sender_idle_pct   = 0;
	int receiver_stall_pct = 0;
	int chars_sent        = 0;
	int error_count       = 0;
	int cycle_count       = 0;

	// predictor state
	logic [63:0] acc;
	logic [1:0]  char_pos;
	logic        hex_seen;
	logic        lead_zero;
	logic [2:0]  err_code;
	logic [7:0]  err_char;

	parse_result_t pending_results[$];
	logic [7:0]    text_buf[$];

	ascii_to_u64_parser_top i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_code  (char_code),
		.is_last    (is_last),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.value      (value),
		.status     (status),
		.bad_char   (bad_char)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("ascii_to_u64_parser_top_test: errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		res_stall <= ($urandom_range(99) < receiver_stall_pct);
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------
	task clear_parse;
		acc       = 64'd0;
		char_pos  = 2'd0;
		hex_seen  = 1'b0;
		lead_zero = 1'b0;
		err_code  = ST_OK;
		err_char  = 8'd0;
	endtask

	task latch_error(input logic [2:0] code, input logic [7:0] ch);
		if (err_code == ST_OK) begin
			err_code = code;
			err_char = ch;
		end
	endtask

	task take_dec(input logic [7:0] ch);
		logic [67:0] wide;
		if (acc > DEC_TOP) begin
			latch_error(ST_OVF_DEC, 8'd0);
		end else if (ch < "0" || ch > "9") begin
			latch_error(ST_BAD_DEC, ch);
		end else begin
			wide = {4'd0, acc} * 68'd10 + {60'd0, ch - 8'h30};
			if (wide[67:64] != 4'd0)
				latch_error(ST_OVF_DEC, 8'd0);
			else
				acc = wide[63:0];
		end
	endtask

	task take_hex(input logic [7:0] ch);
		logic [7:0] d;
		logic       ok;
		if (acc > HEX_LIMIT) begin
			latch_error(ST_OVF_HEX, 8'd0);
		end else begin
			ok = 1'b1;
			d  = 8'd0;
			if (ch >= "0" && ch <= "9")
				d = ch - 8'h30;
			else if (ch >= "a" && ch <= "f")
				d = ch - 8'h61 + 8'd10;
			else if (ch >= "A" && ch <= "F")
				d = ch - 8'h41 + 8'd10;
			else
				ok = 1'b0;
			if (ok)
				acc = {acc[59:0], d[3:0]};
			else
				latch_error(ST_BAD_HEX, ch);
		end
	endtask

	task parse_char(input logic [7:0] ch, input logic last);
		parse_result_t r;
		logic [2:0]    st;
		case (char_pos)
			2'd0: begin
				lead_zero = (ch == "0");
				if (err_code == ST_OK)
					take_dec(ch);
				char_pos = 2'd1;
			end
			2'd1: begin
				if (lead_zero && (ch == "x" || ch == "X") && err_code == ST_OK) begin
					hex_seen = 1'b1;
					acc      = 64'd0;
				end else if (err_code == ST_OK) begin
					take_dec(ch);
				end
				char_pos = 2'd2;
			end
			default: begin
				if (hex_seen) begin
					if (err_code == ST_OK)
						take_hex(ch);
					char_pos = 2'd3;
				end else if (err_code == ST_OK) begin
					take_dec(ch);
				end
			end
		endcase
		if (last) begin
			st = err_code;
			if (st == ST_OK && hex_seen && char_pos != 2'd3)
				st = ST_EMPTY_HEX;
			r.value    = (st == ST_OK) ? acc : 64'd0;
			r.status   = st;
			r.bad_char = (st == ST_BAD_DEC || st == ST_BAD_HEX) ? err_char : 8'd0;
			pending_results.push_back(r);
			clear_parse();
		end
	endtask

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------
	task note_error(input string msg);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
	endtask

	always @(posedge clk) begin : check_results
		parse_result_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				note_error($sformatf("unexpected result value %h status %0d bad_char %h",
					value, status, bad_char));
			end else begin
				e = pending_results.pop_front();
				if (value !== e.value)
					note_error($sformatf("value expected %h got %h", e.value, value));
				if (status !== e.status)
					note_error($sformatf("status expected %0d got %0d", e.status, status));
				if (bad_char !== e.bad_char)
					note_error($sformatf("bad_char expected %h got %h", e.bad_char, bad_char));
			end
		end
	end

	// ------------------------------------------------------------------------
	// driving
	// ------------------------------------------------------------------------
	task send_char(input logic [7:0] ch, input logic last);
		while ($urandom_range(99) < sender_idle_pct) begin
			char_valid <= 1'b0;
			@(posedge clk);
		end
		char_valid <= 1'b1;
		char_code  <= ch;
		is_last    <= last;
		@(posedge clk);
		while (char_stall)
			@(posedge clk);
		chars_sent++;
		parse_char(ch, last);
	endtask

	task send_text;
		foreach (text_buf[i])
			send_char(text_buf[i], i == text_buf.size() - 1);
	endtask

	task push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task drain_results;
		char_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task set_idling(input int sender_pct, input int receiver_pct);
		sender_idle_pct    = sender_pct;
		receiver_stall_pct = receiver_pct;
	endtask

	function automatic logic [63:0] rand_u64();
		logic [63:0] v;
		int          w;
		v = {$urandom, $urandom};
		w = $urandom_range(1, 64);
		return v >> (64 - w);
	endfunction

	// ------------------------------------------------------------------------
	// text builders
	// ------------------------------------------------------------------------
	task build_decimal;
		int n;
		text_buf.delete();
		case ($urandom_range(9))
			0: begin
				// around the 64-bit maximum, last digit decides overflow
				push_str("1844674407370955161");
				text_buf.push_back(8'h30 + 8'($urandom_range(9)));
			end
			1: begin
				n = $urandom_range(20, 22);
				text_buf.push_back(8'h30 + 8'($urandom_range(1, 9)));
				for (int i = 1; i < n; i++)
					text_buf.push_back(8'h30 + 8'($urandom_range(9)));
			end
			2: begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					text_buf.push_back("0");
				push_str($sformatf("%0d", rand_u64()));
			end
			default: push_str($sformatf("%0d", rand_u64()));
		endcase
	endtask

	task build_hex;
		int n;
		text_buf.delete();
		text_buf.push_back("0");
		text_buf.push_back($urandom_range(1) ? "x" : "X");
		case ($urandom_range(15))
			0: ;
			1: begin
				// seventeen or eighteen digits with a nonzero top digit
				push_str($sformatf("%016h", {4'($urandom_range(1, 15)), 28'($urandom),
					$urandom}));
				n = $urandom_range(1, 2);
				for (int i = 0; i < n; i++)
					push_str($sformatf("%h", 4'($urandom)));
			end
			2: begin
				n = $urandom_range(1, 20);
				for (int i = 0; i < n; i++)
					text_buf.push_back("0");
				push_str($sformatf("%0h", rand_u64()));
			end
			default: push_str($sformatf("%0h", rand_u64()));
		endcase
		for (int i = 2; i < text_buf.size(); i++)
			if (text_buf[i] >= "a" && text_buf[i] <= "f" && $urandom_range(1))
				text_buf[i] = text_buf[i] - 8'h20;
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task test_extremes;
		string fixed_texts[];
		fixed_texts = '{"0", "9", "18446744073709551615", "18446744073709551616",
			"184467440737095516150", "0x", "0X", "0xffffffffffffffff",
			"0XFFFFFFFFFFFFFFFF0", "0x1g2", "07", "0y", "x1", "00x1", "0x0", "12a34"};
		foreach (fixed_texts[i]) begin
			text_buf.delete();
			push_str(fixed_texts[i]);
			send_text();
		end
		send_char(8'hff, 1'b1);
		send_char(8'h00, 1'b1);
	endtask

	task test_decimal(input int n_chars);
		int stop_at;
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			build_decimal();
			send_text();
		end
	endtask

	task test_hex(input int n_chars);
		int stop_at;
		stop_at = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			build_hex();
			send_text();
		end
	endtask

	task test_bad_chars(input int n_chars);
		string near_miss;
		int    stop_at;
		int    pos;
		near_miss = "/:@G`gxX -";
		stop_at   = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			if ($urandom_range(1))
				build_decimal();
			else
				build_hex();
			pos = $urandom_range(text_buf.size() - 1);
			if ($urandom_range(3) == 0)
				text_buf[pos] = 8'($urandom_range(255));
			else
				text_buf[pos] = near_miss[$urandom_range(near_miss.len() - 1)];
			if ($urandom_range(3) == 0)
				push_str($sformatf("%0d", $urandom_range(999)));
			send_text();
		end
	endtask

	task test_noise(input int n_chars);
		string hot_chars;
		int    stop_at;
		int    n;
		hot_chars = "0xX9aF";
		stop_at   = chars_sent + n_chars;
		while (chars_sent < stop_at) begin
			text_buf.delete();
			n = $urandom_range(1, 5);
			for (int i = 0; i < n; i++)
				if ($urandom_range(1))
					text_buf.push_back(8'($urandom_range(255)));
				else
					text_buf.push_back(hot_chars[$urandom_range(hot_chars.len() - 1)]);
			send_text();
		end
	endtask

	initial begin
		clear_parse();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0);
		test_extremes();
		drain_results();

		set_idling(69, 0);
		test_decimal(300);
		drain_results();

		set_idling(0, 69);
		test_hex(300);
		drain_results();

		set_idling(13, 13);
		test_bad_chars(300);
		test_hex(100);
		drain_results();

		set_idling(0, 0);
		test_noise(150);
		test_decimal(100);
		drain_results();

		if (error_count == 0 && pending_results.size() == 0) begin
			$display("ascii_to_u64_parser_top_test: clean");
		end else begin
			$display("ascii_to_u64_parser_top_test: errors");
		end
		$finish;
	end

endmodule
